// ----- rtl/sra_pkg.sv -----
// Shared types, constants and helpers of the sector run allocator.
`default_nettype none

package sra_pkg;

  localparam int MaxSectors = 8192;
  localparam int SlotCount  = 1024;
  localparam int HdrSectors = 2;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_LOADED   = 3'd0,
    ST_IN_PLACE = 3'd1,
    ST_MOVED    = 3'd2,
    ST_APPENDED = 3'd3,
    ST_FOUND    = 3'd4,
    ST_EMPTY    = 3'd5,
    ST_INVALID  = 3'd6,
    ST_NO_ROOM  = 3'd7
  } status_t;

  // where the reported sector fields come from
  typedef enum logic [1:0] {
    SRC_ZERO = 2'd0,
    SRC_OLD  = 2'd1,
    SRC_IN   = 2'd2,
    SRC_NEW  = 2'd3
  } src_t;

  typedef struct packed {
    logic    clear_step;
    logic    capture;
    logic    load_commit;
    logic    rng_old;
    logic    rng_val;
    logic    take;
    logic    take_append;
    logic    rng_step;
    logic    scan_init;
    logic    scan_step;
    logic    emit;
    status_t emit_status;
    src_t    emit_src;
  } ctl_t;

  typedef struct packed {
    logic clear_done;
    cmd_t cmd;
    logic too_big;
    logic in_place;
    logic old_valid;
    logic old_zero;
    logic load_fits;
    logic rng_last;
    logic scan_found;
    logic scan_end;
    logic grow_ok;
  } stat_t;

  // entry is nonzero and its sectors lie inside the store
  function automatic logic entry_fits(input logic [31:0] loc, input logic [13:0] total);
    entry_fits = (loc != 32'd0) &&
                 (({1'b0, loc[31:8]} + {17'd0, loc[7:0]}) <= {11'd0, total});
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sra_ctrl.sv -----
// Command sequencer of the sector run allocator.
`default_nettype none

module sra_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  sra_pkg::stat_t stat,
  output sra_pkg::ctl_t  ctl
);
  import sra_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_FREE   = 6'b001000,
    S_SCAN   = 6'b010000,
    S_RANGE  = 6'b100000
  } state_t;

  state_t  state, state_next;
  status_t fin_status, fin_status_next;
  src_t    fin_src, fin_src_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    ctl             = '0;
    state_next      = state;
    fin_status_next = fin_status;
    fin_src_next    = fin_src;
    case (state)
      S_CLEAR: begin
        ctl.clear_step = 1'b1;
        if (stat.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          ctl.capture = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (stat.cmd)
          CMD_LOAD: begin
            ctl.load_commit = 1'b1;
            if (stat.load_fits) begin
              fin_status_next = ST_LOADED;
              fin_src_next    = SRC_IN;
              state_next      = S_RANGE;
            end else begin
              ctl.emit        = 1'b1;
              ctl.emit_status = ST_LOADED;
              ctl.emit_src    = SRC_IN;
              state_next      = S_IDLE;
            end
          end
          CMD_LOOKUP: begin
            ctl.emit   = 1'b1;
            state_next = S_IDLE;
            if (stat.old_zero) begin
              ctl.emit_status = ST_EMPTY;
              ctl.emit_src    = SRC_ZERO;
            end else if (!stat.old_valid) begin
              ctl.emit_status = ST_INVALID;
              ctl.emit_src    = SRC_OLD;
            end else begin
              ctl.emit_status = ST_FOUND;
              ctl.emit_src    = SRC_OLD;
            end
          end
          CMD_WRITE: begin
            if (stat.too_big) begin
              ctl.emit        = 1'b1;
              ctl.emit_status = ST_NO_ROOM;
              ctl.emit_src    = SRC_ZERO;
              state_next      = S_IDLE;
            end else if (stat.in_place) begin
              ctl.emit        = 1'b1;
              ctl.emit_status = ST_IN_PLACE;
              ctl.emit_src    = SRC_OLD;
              state_next      = S_IDLE;
            end else if (stat.old_valid) begin
              // release the old sectors before searching
              ctl.rng_old = 1'b1;
              ctl.rng_val = 1'b0;
              state_next  = S_FREE;
            end else begin
              ctl.scan_init = 1'b1;
              state_next    = S_SCAN;
            end
          end
          default: begin
            ctl.emit        = 1'b1;
            ctl.emit_status = ST_INVALID;
            ctl.emit_src    = SRC_ZERO;
            state_next      = S_IDLE;
          end
        endcase
      end
      S_FREE: begin
        ctl.rng_step = 1'b1;
        if (stat.rng_last) begin
          ctl.scan_init = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (stat.scan_found) begin
          ctl.take        = 1'b1;
          fin_status_next = ST_MOVED;
          fin_src_next    = SRC_NEW;
          state_next      = S_RANGE;
        end else if (stat.scan_end) begin
          if (stat.grow_ok) begin
            ctl.take        = 1'b1;
            ctl.take_append = 1'b1;
            fin_status_next = ST_APPENDED;
            fin_src_next    = SRC_NEW;
            state_next      = S_RANGE;
          end else if (stat.old_valid) begin
            // put the old sectors back in use
            ctl.rng_old     = 1'b1;
            ctl.rng_val     = 1'b1;
            fin_status_next = ST_NO_ROOM;
            fin_src_next    = SRC_ZERO;
            state_next      = S_RANGE;
          end else begin
            ctl.emit        = 1'b1;
            ctl.emit_status = ST_NO_ROOM;
            ctl.emit_src    = SRC_ZERO;
            state_next      = S_IDLE;
          end
        end
      end
      S_RANGE: begin
        ctl.rng_step = 1'b1;
        if (stat.rng_last) begin
          ctl.emit        = 1'b1;
          ctl.emit_status = fin_status;
          ctl.emit_src    = fin_src;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      fin_status <= ST_LOADED;
      fin_src    <= SRC_ZERO;
    end else begin
      state      <= state_next;
      fin_status <= fin_status_next;
      fin_src    <= fin_src_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sra_dp.sv -----
// Datapath of the sector run allocator: tables, sector map, scan and range engines.
`default_nettype none

module sra_dp (
  input  logic           clk,
  input  logic           rst,
  input  sra_pkg::ctl_t  ctl,
  output sra_pkg::stat_t stat,
  input  logic [1:0]     command,
  input  logic [4:0]     slot_x,
  input  logic [4:0]     slot_z,
  input  logic [31:0]    location,
  input  logic [19:0]    compressed_bytes,
  input  logic [31:0]    stamp_in,
  input  logic           cfg_we,
  input  logic [13:0]    initial_sectors,
  output logic           done,
  output logic [2:0]     status,
  output logic [12:0]    sector_start,
  output logic [7:0]     sector_num,
  output logic [31:0]    stamp_out
);
  import sra_pkg::*;

  logic [31:0] loc_mem   [SlotCount];
  logic [31:0] stamp_mem [SlotCount];
  logic        used_mem  [MaxSectors];

  logic [1:0]  cmd_q;
  logic [9:0]  slot_q;
  logic [31:0] loc_in_q;
  logic [8:0]  need_q;
  logic [31:0] stamp_in_q;
  logic [31:0] loc_rd;
  logic [31:0] stamp_rd;
  logic [13:0] total;
  logic [13:0] clr_i;
  logic [12:0] rng_base;
  logic [7:0]  rng_len;
  logic [7:0]  k;
  logic        rng_val;
  logic        rng_skip;
  logic [13:0] scan_i;
  logic [12:0] scan_prev;
  logic        scan_pend;
  logic [12:0] free_base;
  logic [7:0]  run_len;
  logic        used_rd;
  logic [12:0] new_start;

  logic [20:0] bytes_pad;
  logic [8:0]  need_calc;
  logic [13:0] rng_sec;
  logic        rng_act;
  logic [12:0] found_start;
  logic [12:0] take_base;
  logic [14:0] grow_sum;
  logic [13:0] cfg_total;
  logic        tab_we;
  logic        stamp_we;
  logic [9:0]  tab_addr;
  logic [31:0] tab_loc;
  logic [31:0] stamp_wdata;
  logic        used_we;
  logic [12:0] used_addr;
  logic        used_wdata;

  assign bytes_pad = {1'b0, compressed_bytes} + 21'd5;
  assign need_calc = bytes_pad[20:12] + 9'd1;

  assign rng_sec = {1'b0, rng_base} + {6'd0, k};
  assign rng_act = ctl.rng_step && (k < rng_len) &&
                   (!rng_skip || (rng_sec >= 14'(HdrSectors)));

  assign found_start = (run_len == 8'd0) ? scan_prev : free_base;
  assign take_base   = ctl.take_append ? total[12:0] : found_start;
  assign grow_sum    = {1'b0, total} + {6'd0, need_q};

  always_comb begin
    if (initial_sectors < 14'(HdrSectors)) cfg_total = 14'(HdrSectors);
    else if (initial_sectors > 14'(MaxSectors)) cfg_total = 14'(MaxSectors);
    else cfg_total = initial_sectors;
  end

  always_comb begin
    stat.clear_done = (clr_i == 14'(MaxSectors - 1));
    stat.cmd        = cmd_t'(cmd_q);
    stat.too_big    = (need_q > 9'd255);
    stat.old_valid  = entry_fits(loc_rd, total);
    stat.old_zero   = (loc_rd == 32'd0);
    stat.in_place   = (loc_rd[31:8] != 24'd0) && ({1'b0, loc_rd[7:0]} == need_q) &&
                      entry_fits(loc_rd, total);
    stat.load_fits  = entry_fits(loc_in_q, total);
    stat.rng_last   = (({1'b0, k} + 9'd1) >= {1'b0, rng_len});
    stat.scan_found = scan_pend && !used_rd && (({1'b0, run_len} + 9'd1) >= need_q);
    stat.scan_end   = !scan_pend && (scan_i >= total);
    stat.grow_ok    = (grow_sum <= 15'(MaxSectors));
  end

  // table write port
  always_comb begin
    tab_we      = 1'b0;
    stamp_we    = 1'b0;
    tab_addr    = slot_q;
    tab_loc     = loc_in_q;
    stamp_wdata = stamp_in_q;
    if (ctl.clear_step) begin
      tab_we      = (clr_i < 14'(SlotCount));
      stamp_we    = (clr_i < 14'(SlotCount));
      tab_addr    = clr_i[9:0];
      tab_loc     = 32'd0;
      stamp_wdata = 32'd0;
    end else if (ctl.load_commit) begin
      tab_we = 1'b1;
    end else if (ctl.take) begin
      tab_we   = 1'b1;
      stamp_we = 1'b1;
      tab_loc  = {11'd0, take_base, need_q[7:0]};
    end
  end

  // sector map write port
  always_comb begin
    used_we    = 1'b0;
    used_addr  = rng_sec[12:0];
    used_wdata = rng_val;
    if (ctl.clear_step) begin
      used_we    = 1'b1;
      used_addr  = clr_i[12:0];
      used_wdata = (clr_i < 14'(HdrSectors));
    end else if (rng_act) begin
      used_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      loc_rd   <= loc_mem[{slot_z, slot_x}];
      stamp_rd <= stamp_mem[{slot_z, slot_x}];
    end
    if (tab_we) loc_mem[tab_addr] <= tab_loc;
    if (stamp_we) stamp_mem[tab_addr] <= stamp_wdata;
    used_rd <= used_mem[scan_i[12:0]];
    if (used_we) used_mem[used_addr] <= used_wdata;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q      <= command;
      slot_q     <= {slot_z, slot_x};
      loc_in_q   <= location;
      need_q     <= need_calc;
      stamp_in_q <= stamp_in;
    end
    if (ctl.load_commit) begin
      rng_base <= loc_in_q[20:8];
      rng_len  <= loc_in_q[7:0];
      rng_val  <= 1'b1;
      rng_skip <= 1'b0;
      k        <= 8'd0;
    end else if (ctl.rng_old) begin
      rng_base <= loc_rd[20:8];
      rng_len  <= loc_rd[7:0];
      rng_val  <= ctl.rng_val;
      rng_skip <= 1'b1;
      k        <= 8'd0;
    end else if (ctl.take) begin
      rng_base  <= take_base;
      rng_len   <= need_q[7:0];
      rng_val   <= 1'b1;
      rng_skip  <= 1'b0;
      k         <= 8'd0;
      new_start <= take_base;
    end else if (ctl.rng_step) begin
      k <= k + 8'd1;
    end
    if (ctl.scan_init) begin
      scan_i  <= 14'd0;
      run_len <= 8'd0;
    end else if (ctl.scan_step) begin
      if (scan_i < total) begin
        scan_prev <= scan_i[12:0];
        scan_i    <= scan_i + 14'd1;
      end
      if (scan_pend) begin
        if (!used_rd) begin
          if (run_len == 8'd0) free_base <= scan_prev;
          run_len <= run_len + 8'd1;
        end else begin
          run_len <= 8'd0;
        end
      end
    end
    if (ctl.emit) begin
      status <= ctl.emit_status;
      case (ctl.emit_src)
        SRC_OLD: begin
          sector_start <= loc_rd[20:8];
          sector_num   <= loc_rd[7:0];
          stamp_out    <= stamp_rd;
        end
        SRC_IN: begin
          sector_start <= loc_in_q[20:8];
          sector_num   <= loc_in_q[7:0];
          stamp_out    <= stamp_rd;
        end
        SRC_NEW: begin
          sector_start <= new_start;
          sector_num   <= need_q[7:0];
          stamp_out    <= stamp_in_q;
        end
        default: begin
          sector_start <= 13'd0;
          sector_num   <= 8'd0;
          stamp_out    <= stamp_rd;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= 14'(HdrSectors);
      clr_i     <= 14'd0;
      scan_pend <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= ctl.emit;
      if (ctl.clear_step) clr_i <= clr_i + 14'd1;
      if (cfg_we) begin
        total <= cfg_total;
      end else if (ctl.take && ctl.take_append) begin
        total <= total + {5'd0, need_q};
      end
      if (ctl.scan_init) begin
        scan_pend <= 1'b0;
      end else if (ctl.scan_step) begin
        scan_pend <= (scan_i < total);
      end
    end
  end

`ifndef ASSERT_OFF
  a_total_range: assert property (@(posedge clk) disable iff (rst)
    (total >= 14'(HdrSectors)) && (total <= 14'(MaxSectors)))
    else $error("sector total out of range");

  a_write_inside: assert property (@(posedge clk) disable iff (rst)
    rng_act |-> (rng_sec < total))
    else $error("sector map write beyond store end");

  a_append_grow: assert property (@(posedge clk) disable iff (rst)
    (ctl.take && ctl.take_append && !cfg_we) |=>
      (total == 14'($past(total) + {5'd0, $past(need_q)})))
    else $error("append did not grow the store by the need");

  a_new_count: assert property (@(posedge clk) disable iff (rst)
    (done && ((status == ST_MOVED) || (status == ST_APPENDED))) |->
      ((sector_num == need_q[7:0]) && (sector_num != 8'd0)))
    else $error("relocated entry has wrong sector count");
`endif

endmodule

`default_nettype wire

// ----- rtl/sector_run_allocator_core.sv -----
// Top level of the sector run allocator.
`default_nettype none

// After reset the block clears its tables and sector map with busy high. A
// command is taken when start is high and busy is low. Lookup, a load whose
// entry does not fit, and a write that is reused in place or needs more than
// 255 sectors finish straight from the decision state; a load that fits first
// marks its sectors. A relocating write frees any old sectors, searches for a
// free run or appends at the store end, and marks the new run: the free search
// walks the sector map one sector per cycle through its single read port, and
// freeing and marking write one sector per cycle. The result shows on the
// result ports with done high for one cycle and cannot be held off. The sector
// total register accepts a word only while the block is idle.
module sector_run_allocator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [4:0]  slot_x,
  input  logic [4:0]  slot_z,
  input  logic [31:0] location,
  input  logic [19:0] compressed_bytes,
  input  logic [31:0] stamp_in,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [13:0] initial_sectors,
  output logic        done,
  output logic [2:0]  status,
  output logic [12:0] sector_start,
  output logic [7:0]  sector_num,
  output logic [31:0] stamp_out
);
  import sra_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  assign cfg_ready = !busy;

  sra_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctl   (ctl)
  );

  sra_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .stat             (stat),
    .command          (command),
    .slot_x           (slot_x),
    .slot_z           (slot_z),
    .location         (location),
    .compressed_bytes (compressed_bytes),
    .stamp_in         (stamp_in),
    .cfg_we           (cfg_valid && cfg_ready),
    .initial_sectors  (initial_sectors),
    .done             (done),
    .status           (status),
    .sector_start     (sector_start),
    .sector_num       (sector_num),
    .stamp_out        (stamp_out)
  );

endmodule

`default_nettype wire
